FILE: design/tteg_pkg.sv
package tteg_pkg;

    // field and register widths
    localparam int unsigned LEN_W      = 12;
    localparam int unsigned STEP_W     = 16;
    localparam int unsigned PEAK_W     = 15;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // shared unit widths
    localparam int unsigned MUL_W  = 16;
    localparam int unsigned PROD_W = 2 * MUL_W;

    // triangle and envelope scaling
    localparam logic [15:0] TRI_MID     = 16'd32767;
    localparam int unsigned PEAK_SHIFT  = 15;
    localparam int unsigned ATTACK_LEN  = 32;
    localparam int unsigned ATT_SHIFT   = $clog2(ATTACK_LEN);
    localparam int unsigned ATT_W       = ATT_SHIFT + 1;

    // dividend of the decay division: 15-bit level times 12-bit remainder
    localparam int unsigned DVD_W     = 27;
    localparam int unsigned CNT_W     = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

    // register reset values
    localparam logic [LEN_W-1:0]  TONE_LENGTH_RST = 12'd608;
    localparam logic [STEP_W-1:0] STEP_RST        = 16'd3566;
    localparam logic [PEAK_W-1:0] PEAK_RST        = 15'd5000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TONE_LENGTH = 3'd0,
        CFG_SPLIT_MODE  = 3'd1,
        CFG_FIRST_STEP  = 3'd2,
        CFG_SECOND_STEP = 3'd3,
        CFG_PEAK_LEVEL  = 3'd4
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_PEAK,
        ST_MUL_ATT,
        ST_MUL_REM,
        ST_DIV,
        ST_DONE
    } state_t;

    // shared unit operations
    typedef enum logic {
        OP_MUL,
        OP_DIV_STEP
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [MUL_W-1:0]  mul_a;
        logic [MUL_W-1:0]  mul_b;
        logic [LEN_W:0]    part_rem;
        logic [LEN_W-1:0]  divisor;
    } alu_req_t;

    typedef struct packed {
        logic [PROD_W-1:0] product;
        logic [LEN_W-1:0]  rem;
        logic              q_bit;
    } alu_rsp_t;

endpackage

FILE: design/triangle_tone_envelope_generator_top.sv
// Triangle tone generator with linear attack and linear decay. Each input item
// is one sample tick (s_tdata[0] = restart) and gives exactly one result item:
// a signed 16-bit sample on m_tdata, m_tlast on the final sample of the tone and
// m_tuser high while a tone sample is produced. A tick that produces a sample
// goes from acceptance through three multiply passes and 27 one-bit restoring
// divide steps (by tone_length) in the single shared arithmetic unit, then to
// the done state, which hands the item to the output register once that is
// free. An idle tick goes from acceptance straight to the done state. The block
// is not ready while an item is in work; a result waiting in the output register
// does not hold off the next item until that item is done. Configuration is
// written through cfg_wr_en/cfg_index/cfg_wdata; the user must write it only
// while no item is in work, as the block itself does not enforce this.
module triangle_tone_envelope_generator_top
    import tteg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration write port
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    // tick input
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [0] restart, [7:1] zero
    // sample output
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [SAMPLE_W-1:0]     m_tdata,   // [15:0] sample_out
    output logic                    m_tlast,   // final_sample
    output logic                    m_tuser    // [0] playing
);

    // configuration registers
    logic [LEN_W-1:0]  tone_length_reg;
    logic              split_mode_reg;
    logic [STEP_W-1:0] first_step_reg;
    logic [STEP_W-1:0] second_step_reg;
    logic [PEAK_W-1:0] peak_level_reg;

    // tone state
    logic [STEP_W-1:0] phase_reg, phase_next;
    logic [LEN_W-1:0]  index_reg, index_next;
    logic              busy_reg, busy_next;

    // sequencer and work registers
    state_t            state_reg, state_next;
    logic [STEP_W-1:0] work_ph_reg, work_ph_next;
    logic [LEN_W-1:0]  work_idx_reg, work_idx_next;
    logic              active_reg, active_next;
    logic              last_reg, last_next;
    logic              neg_reg, neg_next;
    logic [DVD_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;
    logic                m_tuser_reg, m_tuser_next;

    logic              accept;
    logic              out_free;
    logic              restart;
    logic [STEP_W-1:0] ph_start;
    logic [LEN_W-1:0]  idx_start;
    logic [LEN_W:0]    idx_inc;
    logic              run;
    logic              tone_ok;
    logic [STEP_W-1:0] step;
    logic [15:0]       tri_w;
    logic [15:0]       tri_mag;
    logic              tri_neg;
    logic [ATT_W-1:0]  att;
    logic [LEN_W-1:0]  remain;
    logic [SAMPLE_W-1:0] sample_mag;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    tteg_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign restart  = s_tdata[0];

    // per-tick tone control
    always_comb begin
        ph_start  = restart ? '0 : phase_reg;
        idx_start = restart ? '0 : index_reg;
        run       = restart || busy_reg;
        tone_ok   = run && (tone_length_reg != '0) && (idx_start < tone_length_reg);
        idx_inc   = {1'b0, idx_start} + (LEN_W+1)'(1);
        step      = (split_mode_reg && (idx_start >= (tone_length_reg >> 1)))
                    ? second_step_reg : first_step_reg;
    end

    // triangle magnitude and sign, attack factor and remaining count
    always_comb begin
        tri_w   = {work_ph_reg[14:0], 1'b0};
        tri_mag = (tri_w > TRI_MID) ? (tri_w - TRI_MID) : (TRI_MID - tri_w);
        tri_neg = (tri_w < TRI_MID) ^ work_ph_reg[15];
        att     = (work_idx_reg < LEN_W'(ATTACK_LEN)) ? work_idx_reg[ATT_W-1:0]
                                                      : ATT_W'(ATTACK_LEN);
        remain  = tone_length_reg - work_idx_reg - LEN_W'(1);
        sample_mag = acc_reg[SAMPLE_W-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = tone_ok ? ST_MUL_PEAK : ST_DONE;
                end
            end
            ST_MUL_PEAK: state_next = ST_MUL_ATT;
            ST_MUL_ATT:  state_next = ST_MUL_REM;
            ST_MUL_REM:  state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        phase_next    = phase_reg;
        index_next    = index_reg;
        busy_next     = busy_reg;
        work_ph_next  = work_ph_reg;
        work_idx_next = work_idx_reg;
        active_next   = active_reg;
        last_next     = last_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        alu_req.op       = OP_MUL;
        alu_req.mul_a    = '0;
        alu_req.mul_b    = '0;
        alu_req.part_rem = {rem_reg, acc_reg[DVD_W-1]};
        alu_req.divisor  = tone_length_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    work_ph_next  = ph_start;
                    work_idx_next = idx_start;
                    active_next   = tone_ok;
                    last_next     = tone_ok && (idx_inc == {1'b0, tone_length_reg});
                    if (tone_ok) begin
                        phase_next = ph_start + step;
                        if (idx_inc >= {1'b0, tone_length_reg}) begin
                            busy_next  = 1'b0;
                            index_next = '0;
                        end else begin
                            busy_next  = 1'b1;
                            index_next = idx_inc[LEN_W-1:0];
                        end
                    end else if (run) begin
                        busy_next  = 1'b0;
                        phase_next = ph_start;
                        index_next = idx_start;
                    end
                end
            end
            ST_MUL_PEAK: begin
                alu_req.mul_a = tri_mag;
                alu_req.mul_b = MUL_W'(peak_level_reg);
                neg_next      = tri_neg;
                acc_next      = DVD_W'(alu_rsp.product[PEAK_SHIFT +: MUL_W]);
            end
            ST_MUL_ATT: begin
                alu_req.mul_a = acc_reg[MUL_W-1:0];
                alu_req.mul_b = MUL_W'(att);
                acc_next      = DVD_W'(alu_rsp.product[ATT_SHIFT +: MUL_W]);
            end
            ST_MUL_REM: begin
                alu_req.mul_a = acc_reg[MUL_W-1:0];
                alu_req.mul_b = MUL_W'(remain);
                acc_next      = alu_rsp.product[DVD_W-1:0];
                rem_next      = '0;
                cnt_next      = '0;
            end
            ST_DIV: begin
                alu_req.op = OP_DIV_STEP;
                acc_next   = {acc_reg[DVD_W-2:0], alu_rsp.q_bit};
                rem_next   = alu_rsp.rem;
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = last_reg;
                    m_tuser_next  = active_reg;
                    if (!active_reg) begin
                        m_tdata_next = '0;
                    end else if (neg_reg) begin
                        m_tdata_next = SAMPLE_W'(0) - sample_mag;
                    end else begin
                        m_tdata_next = sample_mag;
                    end
                end
            end
            default: begin
                m_tvalid_next = m_tvalid_reg && !m_tready;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_length_reg <= TONE_LENGTH_RST;
            split_mode_reg  <= 1'b0;
            first_step_reg  <= STEP_RST;
            second_step_reg <= STEP_RST;
            peak_level_reg  <= PEAK_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TONE_LENGTH: tone_length_reg <= cfg_wdata[LEN_W-1:0];
                CFG_SPLIT_MODE:  split_mode_reg  <= cfg_wdata[0];
                CFG_FIRST_STEP:  first_step_reg  <= cfg_wdata[STEP_W-1:0];
                CFG_SECOND_STEP: second_step_reg <= cfg_wdata[STEP_W-1:0];
                CFG_PEAK_LEVEL:  peak_level_reg  <= cfg_wdata[PEAK_W-1:0];
                default: begin
                    split_mode_reg <= split_mode_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            index_reg    <= '0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            index_reg    <= index_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
    end

    // work and output payload
    always_ff @(posedge aclk) begin
        work_ph_reg  <= work_ph_next;
        work_idx_reg <= work_idx_next;
        active_reg   <= active_next;
        last_reg     <= last_next;
        neg_reg      <= neg_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    // the last divide step always hands over to the output stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == DIV_LAST) |=> (state_reg == ST_DONE))
        else $error("divide did not finish after its last step");

    // partial remainder stays below the tone length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < tone_length_reg))
        else $error("divide remainder out of range");

    // the final sample of a tone is always a playing sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("final sample flagged while not playing");

    // one item in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input ready right after an accepted item");
`endif

endmodule

FILE: design/tteg_alu.sv
module tteg_alu
    import tteg_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [LEN_W+1:0] trial;

    // one multiply or one restoring divide step per cycle
    always_comb begin
        trial       = {1'b0, req.part_rem} - {2'b00, req.divisor};
        rsp.product = '0;
        rsp.rem     = '0;
        rsp.q_bit   = 1'b0;
        unique case (req.op)
            OP_MUL: begin
                rsp.product = req.mul_a * req.mul_b;
            end
            OP_DIV_STEP: begin
                if (!trial[LEN_W+1]) begin
                    rsp.rem   = trial[LEN_W-1:0];
                    rsp.q_bit = 1'b1;
                end else begin
                    rsp.rem   = req.part_rem[LEN_W-1:0];
                    rsp.q_bit = 1'b0;
                end
            end
            default: begin
                rsp.product = '0;
            end
        endcase
    end

endmodule

FILE: dv/tone_sample_checker.sv
module tone_sample_checker
    import tteg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_out
    input  logic                  m_tlast,   // final_sample
    input  logic                  m_tuser,   // [0] playing
    output int                    error_count,
    output int                    pending
);

    localparam longint FULL_SCALE = 32768;
    localparam longint TRI_OFFSET = 32767;
    localparam longint TRI_FOLD   = 98303;
    localparam logic [STEP_W-1:0] HALF_PHASE = 16'h8000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic                is_last;
        logic                active;
    } tone_out_t;

    // register copies
    logic [LEN_W-1:0]  len_q;
    logic              split_q;
    logic [STEP_W-1:0] step1_q;
    logic [STEP_W-1:0] step2_q;
    logic [PEAK_W-1:0] peak_q;

    // tone state
    logic [STEP_W-1:0] tone_phase;
    logic [LEN_W-1:0]  tone_index;
    logic              tone_busy;

    tone_out_t expected_samples[$];

    // one sample tick: returns the sample and advances the tone
    function automatic tone_out_t predict_tick(input logic restart);
        tone_out_t   res;
        longint      tri_val;
        longint      acc;
        longint      att;
        longint      remain;
        int unsigned nxt;
        logic [STEP_W-1:0] step;
        res = '0;
        if (restart) begin
            tone_phase = '0;
            tone_index = '0;
            tone_busy  = 1'b1;
        end
        if (!tone_busy)
            return res;
        // zero length or length lowered below the running index
        if (len_q == '0 || tone_index >= len_q) begin
            tone_busy = 1'b0;
            return res;
        end
        // triangle from the phase, then peak, attack and decay scaling
        if (tone_phase < HALF_PHASE)
            tri_val = longint'(tone_phase) * 2 - TRI_OFFSET;
        else
            tri_val = TRI_FOLD - longint'(tone_phase) * 2;
        att = (tone_index < ATTACK_LEN) ? longint'(tone_index) : longint'(ATTACK_LEN);
        remain = longint'(len_q) - 1 - longint'(tone_index);
        acc = tri_val * longint'(peak_q) / FULL_SCALE;
        acc = acc * att / longint'(ATTACK_LEN);
        acc = acc * remain / longint'(len_q);
        res.level   = acc[SAMPLE_W-1:0];
        res.is_last = (tone_index == len_q - 1'b1);
        res.active  = 1'b1;
        // advance phase with the step of this sample
        step = (split_q && tone_index >= len_q / 2) ? step2_q : step1_q;
        tone_phase = tone_phase + step;
        nxt = tone_index + 1;
        tone_index = nxt[LEN_W-1:0];
        if (nxt >= len_q) begin
            tone_busy  = 1'b0;
            tone_index = '0;
        end
        return res;
    endfunction

    initial begin
        error_count = 0;
        pending     = 0;
    end

    // track config, predict on input items, compare on output items
    always @(posedge aclk) begin
        tone_out_t want;
        if (!aresetn) begin
            len_q      = TONE_LENGTH_RST;
            split_q    = 1'b0;
            step1_q    = STEP_RST;
            step2_q    = STEP_RST;
            peak_q     = PEAK_RST;
            tone_phase = '0;
            tone_index = '0;
            tone_busy  = 1'b0;
            expected_samples.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TONE_LENGTH: len_q   = cfg_wdata[LEN_W-1:0];
                    CFG_SPLIT_MODE:  split_q = cfg_wdata[0];
                    CFG_FIRST_STEP:  step1_q = cfg_wdata[STEP_W-1:0];
                    CFG_SECOND_STEP: step2_q = cfg_wdata[STEP_W-1:0];
                    CFG_PEAK_LEVEL:  peak_q  = cfg_wdata[PEAK_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_samples.push_back(predict_tick(s_tdata[0]));
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected item: sample %0d last %b playing %b",
                             $time, $signed(m_tdata), m_tlast, m_tuser);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want.level) begin
                        error_count++;
                        $display("%0t: sample_out expected %0d actual %0d", $time,
                                 $signed(want.level), $signed(m_tdata));
                    end
                    if (m_tlast !== want.is_last) begin
                        error_count++;
                        $display("%0t: final_sample expected %b actual %b", $time,
                                 want.is_last, m_tlast);
                    end
                    if (m_tuser !== want.active) begin
                        error_count++;
                        $display("%0t: playing expected %b actual %b", $time,
                                 want.active, m_tuser);
                    end
                end
            end
        end
        pending = expected_samples.size();
    end

endmodule

FILE: dv/tb_triangle_tone_envelope_generator_top.sv
module tb_triangle_tone_envelope_generator_top;
    import tteg_pkg::*;

    localparam int RANDOM_ITEMS     = 1925;
    localparam int LONG_HOLD        = 400;
    localparam int HOLD_PHASE       = 3;
    localparam int CFG_FIRST_UNUSED = CFG_PEAK_LEVEL + 1;
    localparam int CFG_LAST_UNUSED  = 2 ** CFG_IDX_W - 1;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [0] restart, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SAMPLE_W-1:0]   m_tdata;   // [15:0] sample_out
    logic                  m_tlast;   // final_sample
    logic                  m_tuser;   // [0] playing

    int                    error_count;
    int                    pending;

    logic [LEN_W-1:0]      cur_len;
    bit                    sender_burst;
    bit                    rx_burst;
    bit                    hold_req;

    triangle_tone_envelope_generator_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    tone_sample_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .error_count (error_count),
        .pending     (pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int draw_gap();
        return sender_burst ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 16'($urandom_range(0, 1023));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // one register write; bits above the register width carry noise
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] noise;
        case (idx)
            CFG_TONE_LENGTH: mask = 16'h0FFF;
            CFG_SPLIT_MODE:  mask = 16'h0001;
            CFG_PEAK_LEVEL:  mask = 16'h7FFF;
            default:         mask = 16'hFFFF;
        endcase
        noise = 16'($urandom_range(0, 65535));
        if (idx == CFG_TONE_LENGTH)
            cur_len = value[LEN_W-1:0];
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= (noise & ~mask) | (value & mask);
        @(posedge aclk);
    endtask

    // write all registers or a random subset
    task automatic apply_settings(input logic [LEN_W-1:0] len, input logic split,
                                  input logic [STEP_W-1:0] step1, input logic [STEP_W-1:0] step2,
                                  input logic [PEAK_W-1:0] peak, input bit write_all);
        if (write_all || $urandom_range(0, 1)) put_reg(CFG_TONE_LENGTH, 16'(len));
        if (write_all || $urandom_range(0, 1)) put_reg(CFG_SPLIT_MODE, 16'(split));
        if (write_all || $urandom_range(0, 1)) put_reg(CFG_FIRST_STEP, step1);
        if (write_all || $urandom_range(0, 1)) put_reg(CFG_SECOND_STEP, step2);
        if (write_all || $urandom_range(0, 1)) put_reg(CFG_PEAK_LEVEL, 16'(peak));
        cfg_wr_en <= 1'b0;
    endtask

    // offer one tick item after a gap and wait for its acceptance
    task automatic send_tick(input logic restart, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering until every expected item has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (2) @(posedge aclk);
    endtask

    // receiver: random stalls, bursts, and one long hold
    initial begin
        int gap;
        int served;
        m_tready = 1'b0;
        rx_burst = 1'b0;
        served   = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (served % 64 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, 13);
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = LONG_HOLD;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            served++;
        end
    end

    // stimulus
    initial begin
        int                random_sent;
        int                phase_no;
        int                n;
        int                since;
        logic              restart;
        logic [LEN_W-1:0]  nxt_len;
        logic [PEAK_W-1:0] nxt_peak;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cur_len      = TONE_LENGTH_RST;
        sender_burst = 1'b0;
        hold_req     = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle tick, then a short stretch of the reset tone
        send_tick(1'b0, draw_gap());
        send_tick(1'b1, draw_gap());
        repeat (2) send_tick(1'b0, draw_gap());

        // zero tone length: restart starts nothing
        drain();
        apply_settings(12'd0, 1'b0, STEP_RST, STEP_RST, PEAK_RST, 1'b1);
        send_tick(1'b1, draw_gap());
        send_tick(1'b0, draw_gap());

        // single-sample tone at full peak
        drain();
        apply_settings(12'd1, 1'b0, STEP_RST, STEP_RST, '1, 1'b1);
        send_tick(1'b1, draw_gap());
        send_tick(1'b0, draw_gap());

        // split mode with extreme steps, restart while playing
        drain();
        apply_settings(12'd40, 1'b1, '1, '0, '1, 1'b1);
        send_tick(1'b1, draw_gap());
        repeat (4) send_tick(1'b0, draw_gap());
        send_tick(1'b1, draw_gap());
        repeat (2) send_tick(1'b0, draw_gap());

        // longest tone, then length lowered below the running index
        drain();
        apply_settings('1, 1'b0, 16'h4000, '1, '1, 1'b1);
        send_tick(1'b1, draw_gap());
        repeat (3) send_tick(1'b0, draw_gap());
        drain();
        put_reg(CFG_TONE_LENGTH, 16'd2);
        cfg_wr_en <= 1'b0;
        send_tick(1'b0, draw_gap());

        // writes to unused register indexes change nothing
        drain();
        for (int k = CFG_FIRST_UNUSED; k <= CFG_LAST_UNUSED; k++)
            put_reg(CFG_IDX_W'(k), 16'($urandom_range(0, 65535)));
        cfg_wr_en <= 1'b0;
        send_tick(1'b1, draw_gap());
        repeat (2) send_tick(1'b0, draw_gap());

        // random phases: mostly whole tones with random settings
        random_sent = 0;
        phase_no    = 0;
        while (random_sent < RANDOM_ITEMS) begin
            drain();
            case ($urandom_range(0, 11))
                0:       nxt_len = '0;
                1:       nxt_len = 12'd1;
                2:       nxt_len = '1;
                3:       nxt_len = 12'($urandom_range(73, 700));
                default: nxt_len = 12'($urandom_range(2, 72));
            endcase
            case ($urandom_range(0, 4))
                0:       nxt_peak = '0;
                1:       nxt_peak = '1;
                default: nxt_peak = 15'($urandom_range(0, 32767));
            endcase
            apply_settings(nxt_len, 1'($urandom_range(0, 1)), pick_step(), pick_step(), nxt_peak,
                           phase_no == 0);
            sender_burst = ($urandom_range(0, 3) == 0);
            if (phase_no == HOLD_PHASE) begin
                hold_req     = 1'b1;
                sender_burst = 1'b1;
            end
            n     = $urandom_range(30, 110);
            since = 0;
            for (int i = 0; i < n; i++) begin
                if (i == 0)
                    restart = ($urandom_range(0, 7) != 0);
                else if (since >= cur_len)
                    restart = ($urandom_range(0, 3) != 0);
                else
                    restart = ($urandom_range(0, 49) == 0);
                // pause mid-phase until the output side has caught up
                if (i == n / 2 && (phase_no == 1 || $urandom_range(0, 5) == 0))
                    drain();
                send_tick(restart, draw_gap());
                since = restart ? 1 : since + 1;
            end
            random_sent += n;
            phase_no++;
        end

        drain();
        repeat (40) @(posedge aclk);
        if (error_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
